/* src/text_console_char_engine_macros.svh */
// ----------------------------------------------------------------------------
// Text console character engine: assertion macros
// Simulation-only property checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCCE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCCE_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* src/tcce_pkg.sv */
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Field widths
  localparam int CH_W    = 8;
  localparam int ATTR_W  = 8;
  localparam int POS_W   = 11;
  localparam int WORD_W  = 16;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;

  // Attribute after reset
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd240;

  // Control codes
  localparam logic [CH_W-1:0] CODE_BS = 8'd8;
  localparam logic [CH_W-1:0] CODE_HT = 8'd9;
  localparam logic [CH_W-1:0] CODE_LF = 8'd10;
  localparam logic [CH_W-1:0] CODE_VT = 8'd11;
  localparam logic [CH_W-1:0] CODE_FF = 8'd12;
  localparam logic [CH_W-1:0] CODE_CR = 8'd13;

  // Rounding masks: tab stops every four columns, vertical tab to even rows
  localparam logic [COL_W:0] TAB_MASK      = ~8'h03;
  localparam logic [ROW_W:0] ROW_EVEN_MASK = ~6'h01;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CELL   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t               kind;
    logic [POS_W-1:0]    cell_index;
    logic [WORD_W-1:0]   cell_word;
    logic [POS_W-1:0]    cursor_pos;
    logic                last;
  } result_t;

  // Results caused by one character
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } res_pair_t;

endpackage

/* src/tcce_cursor.sv */
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor row/column state, control-code moves, wrap and result generation.
// ----------------------------------------------------------------------------
module tcce_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [tcce_pkg::CH_W-1:0]   ch,
  input  logic [tcce_pkg::ATTR_W-1:0] attribute,
  output tcce_pkg::res_pair_t         pair
);

  localparam int LIN_W = 13;
  localparam logic [tcce_pkg::COL_W:0] COLS_L = (tcce_pkg::COL_W + 1)'(COLUMNS);
  localparam logic [tcce_pkg::ROW_W:0] ROWS_L = (tcce_pkg::ROW_W + 1)'(ROWS);
  localparam logic [LIN_W-1:0]         COLS_M = LIN_W'(COLUMNS);

  logic [tcce_pkg::ROW_W-1:0] row;
  logic [tcce_pkg::COL_W-1:0] col;
  logic [tcce_pkg::ROW_W-1:0] row_next;
  logic [tcce_pkg::COL_W-1:0] col_next;

  logic [tcce_pkg::COL_W-1:0] col_dec;
  logic [tcce_pkg::COL_W:0]   col_w;
  logic [tcce_pkg::ROW_W:0]   row_w;
  logic [tcce_pkg::COL_W:0]   col_n;
  logic [tcce_pkg::ROW_W:0]   row_n;
  logic                       printable;
  logic                       is_ff;
  logic [LIN_W-1:0]           old_lin;
  logic [LIN_W-1:0]           new_lin;

  // Column minus one, saturating at zero
  assign col_dec = (col != '0) ? col - 1'b1 : '0;

  // Move the cursor for this character
  always_comb begin
    col_w     = {1'b0, col};
    row_w     = {1'b0, row};
    printable = 1'b0;
    is_ff     = 1'b0;
    case (ch)
      tcce_pkg::CODE_BS: begin
        col_w = {1'b0, col_dec};
      end
      tcce_pkg::CODE_HT: begin
        col_w = ({1'b0, col} + (tcce_pkg::COL_W + 1)'(4)) & tcce_pkg::TAB_MASK;
      end
      tcce_pkg::CODE_LF: begin
        col_w = '0;
        row_w = {1'b0, row} + 1'b1;
      end
      tcce_pkg::CODE_VT: begin
        row_w = ({1'b0, row} + (tcce_pkg::ROW_W + 1)'(2)) & tcce_pkg::ROW_EVEN_MASK;
        col_w = {1'b0, col_dec};
      end
      tcce_pkg::CODE_FF: begin
        col_w = '0;
        row_w = '0;
        is_ff = 1'b1;
      end
      tcce_pkg::CODE_CR: begin
        col_w = '0;
      end
      default: begin
        printable = 1'b1;
        col_w     = {1'b0, col} + 1'b1;
      end
    endcase
  end

  // Line wrap, then row wrap to zero
  always_comb begin
    col_n = col_w;
    row_n = row_w;
    if (col_w >= COLS_L) begin
      col_n = '0;
      row_n = row_w + 1'b1;
    end
    if (row_n >= ROWS_L) begin
      row_n = '0;
    end
  end

  assign col_next = col_n[tcce_pkg::COL_W-1:0];
  assign row_next = row_n[tcce_pkg::ROW_W-1:0];

  // Linear positions before and after the move
  assign old_lin = LIN_W'(row) * COLS_M + LIN_W'(col);
  assign new_lin = LIN_W'(row_next) * COLS_M + LIN_W'(col_next);

  // Build the result beats
  always_comb begin
    pair        = '0;
    if (is_ff) begin
      pair.first.kind = tcce_pkg::KIND_CLEAR;
      pair.first.last = 1'b1;
    end else if (printable) begin
      pair.first.kind        = tcce_pkg::KIND_CELL;
      pair.first.cell_index  = old_lin[tcce_pkg::POS_W-1:0];
      pair.first.cell_word   = {attribute, ch};
      pair.second.kind       = tcce_pkg::KIND_CURSOR;
      pair.second.cursor_pos = new_lin[tcce_pkg::POS_W-1:0];
      pair.second.last       = 1'b1;
      pair.two               = 1'b1;
    end else begin
      pair.first.kind       = tcce_pkg::KIND_CURSOR;
      pair.first.cursor_pos = new_lin[tcce_pkg::POS_W-1:0];
      pair.first.last       = 1'b1;
    end
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (fire) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

/* src/tcce_out_buf.sv */
// ----------------------------------------------------------------------------
// tcce_out_buf
// Two-slot result buffer: output register plus one pending beat.
// ----------------------------------------------------------------------------
`include "text_console_char_engine_macros.svh"

module tcce_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  tcce_pkg::res_pair_t pair,
  input  logic                out_stall,
  output logic                space,
  output logic                head_valid,
  output tcce_pkg::result_t   head
);

  logic              pend_valid;
  tcce_pkg::result_t pend;
  logic              take;

  assign take  = head_valid && !out_stall;
  // Both results of a character must fit once the head beat leaves
  assign space = !pend_valid && (!head_valid || !out_stall);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (fire) begin
      head_valid <= 1'b1;
      pend_valid <= pair.two;
    end else if (take) begin
      head_valid <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (fire) begin
      head <= pair.first;
      pend <= pair.second;
    end else if (take) begin
      head <= pend;
    end
  end

  `TCCE_ASSERT_IMP(a_pend_behind_head, clk, rst, pend_valid, head_valid,
                   "pending beat without head beat")
  `TCCE_ASSERT_IMP(a_cell_has_follow, clk, rst, head_valid && !head.last, pend_valid,
                   "cell write without its cursor update")
  `TCCE_ASSERT_NXT(a_pair_loaded, clk, rst, fire && pair.two, head_valid && pend_valid,
                   "second result lost")
  `TCCE_ASSERT_IMP(a_pend_is_last, clk, rst, pend_valid, pend.last,
                   "pending beat not final")

endmodule

/* src/text_console_char_engine.sv */
// ----------------------------------------------------------------------------
// text_console_char_engine: bytes pass the input register, then the output register.
// Printable byte: two beats, then the next byte; others: one per cycle unless stalled.
// Rate set by the single output port; synchronous reset homes cursor, attribute 240.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcce_pkg::CH_W-1:0]   ch,
  input  logic                        last_of_string,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [tcce_pkg::POS_W-1:0]  cell_index,
  output logic [tcce_pkg::WORD_W-1:0] cell_word,
  output logic [tcce_pkg::POS_W-1:0]  cursor_pos,
  output logic                        last
);

  logic [tcce_pkg::ATTR_W-1:0] attribute;
  logic                        in_q_valid;
  logic [tcce_pkg::CH_W-1:0]   ch_q;
  logic                        space;
  logic                        fire;
  tcce_pkg::res_pair_t         pair;
  tcce_pkg::result_t           head;

  // last_of_string only marks string ends for the source; it steers nothing here

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcce_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attribute <= cfg_wdata;
    end
  end

  // Input register
  assign fire     = in_q_valid && space;
  assign in_stall = in_q_valid && !space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch_q <= ch;
    end
  end

  tcce_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ch        (ch_q),
    .attribute (attribute),
    .pair      (pair)
  );

  tcce_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .pair       (pair),
    .out_stall  (out_stall),
    .space      (space),
    .head_valid (out_valid),
    .head       (head)
  );

  // Result beat fields
  assign kind       = head.kind;
  assign cell_index = head.cell_index;
  assign cell_word  = head.cell_word;
  assign cursor_pos = head.cursor_pos;
  assign last       = head.last;

endmodule

/* bench/tb_text_console_char_engine.sv */
// ----------------------------------------------------------------------------
// tb_text_console_char_engine
// Self-checking bench for the text console character engine. Bytes go in as
// single beats; a cursor tracker in the bench predicts the cell writes, cursor
// updates and clear requests, which are checked beat by beat as they leave.
// Directed control codes and byte extremes come first, then attribute
// settings, a long output hold, and segments of random text lines, tab runs,
// vertical moves and noise, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_text_console_char_engine;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int RANDOM_CHARS = 500;
  localparam int LONG_HOLD    = 250;
  localparam int SETTLE       = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [tcce_pkg::ATTR_W-1:0]   cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [tcce_pkg::CH_W-1:0]     ch;
  logic                          last_of_string;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    kind;
  logic [tcce_pkg::POS_W-1:0]    cell_index;
  logic [tcce_pkg::WORD_W-1:0]   cell_word;
  logic [tcce_pkg::POS_W-1:0]    cursor_pos;
  logic                          last;

  // Cursor tracker and expected screen operations
  int                            trk_row;
  int                            trk_col;
  logic [tcce_pkg::ATTR_W-1:0]   trk_attr;
  tcce_pkg::result_t             pending_screen_ops[$];

  // Pacing and bookkeeping
  int tx_gap_max  = 12;
  int rx_gap_max  = 12;
  int rx_hold_req = 0;
  int fail_count  = 0;
  int chars_sent  = 0;
  int cells_seen  = 0;
  int clears_seen = 0;
  int attr_writes = 0;
  int idle_cycles = 0;

  text_console_char_engine #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .last_of_string(last_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .cell_index    (cell_index),
    .cell_word     (cell_word),
    .cursor_pos    (cursor_pos),
    .last          (last)
  );

  always #2 clk = ~clk;

  // Linear screen position, cut to the port width
  function automatic logic [tcce_pkg::POS_W-1:0] screen_pos(input int r, input int c);
    screen_pos = (tcce_pkg::POS_W)'(r * SCREEN_COLS + c);
  endfunction

  // Cursor movement for one byte; queues the screen operations it causes
  function automatic void advance_cursor(input logic [tcce_pkg::CH_W-1:0] c);
    tcce_pkg::result_t op;
    op = '0;
    case (c)
      tcce_pkg::CODE_BS: if (trk_col > 0) trk_col--;
      tcce_pkg::CODE_HT: trk_col = (trk_col / 4 + 1) * 4;
      tcce_pkg::CODE_LF: begin
        trk_col = 0;
        trk_row++;
      end
      tcce_pkg::CODE_VT: begin
        trk_row = (trk_row / 2 + 1) * 2;
        if (trk_col > 0) trk_col--;
      end
      tcce_pkg::CODE_FF: begin
        trk_row = 0;
        trk_col = 0;
        op.kind = tcce_pkg::KIND_CLEAR;
        op.last = 1'b1;
        pending_screen_ops.push_back(op);
        return;
      end
      tcce_pkg::CODE_CR: trk_col = 0;
      default: begin
        op.kind       = tcce_pkg::KIND_CELL;
        op.cell_index = screen_pos(trk_row, trk_col);
        op.cell_word  = {trk_attr, c};
        pending_screen_ops.push_back(op);
        trk_col++;
      end
    endcase
    // wrap past the last column, then past the bottom row
    if (trk_col >= SCREEN_COLS) begin
      trk_col = 0;
      trk_row++;
    end
    if (trk_row >= SCREEN_ROWS) trk_row = 0;
    op            = '0;
    op.kind       = tcce_pkg::KIND_CURSOR;
    op.cursor_pos = screen_pos(trk_row, trk_col);
    op.last       = 1'b1;
    pending_screen_ops.push_back(op);
  endfunction

  // Any byte that is written as a cell
  function automatic logic [tcce_pkg::CH_W-1:0] pick_printable();
    logic [tcce_pkg::CH_W-1:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c >= tcce_pkg::CODE_BS && c <= tcce_pkg::CODE_CR);
    return c;
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_char(input logic [tcce_pkg::CH_W-1:0] c, input logic eos);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    ch             <= c;
    last_of_string <= eos;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_cursor(c);
    chars_sent++;
  endtask

  // Sender pause: stop offering and let every queued operation come out
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_screen_ops.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [tcce_pkg::ATTR_W-1:0] value);
    wait_results_done();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    trk_attr = value;
    attr_writes++;
  endtask

  // Every control code, saturation cases and byte extremes
  task automatic test_control_codes();
    send_char(tcce_pkg::CODE_BS, 1'b0);   // backspace stuck at column zero
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(tcce_pkg::CODE_HT, 1'b0);   // tab from a stop goes to the next one
    send_char(tcce_pkg::CODE_HT, 1'b0);
    send_char(tcce_pkg::CODE_BS, 1'b1);
    send_char(tcce_pkg::CODE_VT, 1'b0);   // even row, column above zero
    send_char(tcce_pkg::CODE_VT, 1'b0);
    send_char(8'h07, 1'b0);               // other control bytes are written as cells
    send_char(8'h0E, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b1);
    send_char(tcce_pkg::CODE_CR, 1'b0);
    send_char(tcce_pkg::CODE_VT, 1'b0);   // column already zero
    send_char(tcce_pkg::CODE_LF, 1'b0);
    send_char(tcce_pkg::CODE_VT, 1'b0);   // odd row
    send_char(8'h20, 1'b0);
    send_char(8'h41, 1'b1);
    send_char(tcce_pkg::CODE_FF, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b1);
    wait_results_done();
  endtask

  // Attribute at both extremes and one in between
  task automatic test_attribute_extremes();
    logic [tcce_pkg::ATTR_W-1:0] setting [3];
    int i;
    int k;
    setting = '{8'h00, 8'hFF, 8'h5A};
    for (i = 0; i < 3; i++) begin
      write_attribute(setting[i]);
      for (k = 0; k < 4; k++) send_char(pick_printable(), k == 3);
    end
    wait_results_done();
  endtask

  // Long output hold while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int i;
    tx_gap_max  = 0;
    rx_gap_max  = 0;
    rx_hold_req = LONG_HOLD;
    for (i = 0; i < 40; i++) send_char(pick_printable(), i == 39);
    wait_results_done();
    rx_hold_req = LONG_HOLD;
    for (i = 0; i < 30; i++)
      send_char($urandom_range(0, 3) == 0 ?
                  8'($urandom_range(tcce_pkg::CODE_BS, tcce_pkg::CODE_CR)) :
                  pick_printable(), 1'b0);
    wait_results_done();
    tx_gap_max = 12;
    rx_gap_max = 12;
  endtask

  // Segments of text lines, tab runs, vertical moves, noise and settings
  task automatic test_random_text();
    int stop_at;
    int n;
    int k;
    stop_at = chars_sent + RANDOM_CHARS;
    while (chars_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
        1: begin tx_gap_max = 12; rx_gap_max = 12; end
        2: begin tx_gap_max = 0;  rx_gap_max = 12; end
        default: begin tx_gap_max = 2; rx_gap_max = 0; end
      endcase
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          // text line, long enough at times to wrap
          n = $urandom_range(0, 100);
          for (k = 0; k < n; k++) send_char(pick_printable(), k == n - 1);
          if ($urandom_range(0, 1)) send_char(tcce_pkg::CODE_CR, 1'b0);
          send_char(tcce_pkg::CODE_LF, 1'b1);
        end
        4: begin
          n = $urandom_range(1, 25);
          for (k = 0; k < n; k++)
            send_char($urandom_range(0, 4) == 0 ? pick_printable() : tcce_pkg::CODE_HT,
                      1'($urandom_range(0, 1)));
        end
        5, 6: begin
          // vertical moves, enough to wrap past the bottom row
          n = $urandom_range(1, 20);
          for (k = 0; k < n; k++)
            send_char($urandom_range(0, 1) ? tcce_pkg::CODE_VT : tcce_pkg::CODE_LF,
                      1'($urandom_range(0, 1)));
        end
        7: begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++)
            send_char($urandom_range(0, 2) == 0 ? pick_printable() : tcce_pkg::CODE_BS,
                      1'($urandom_range(0, 1)));
        end
        8, 9: begin
          n = $urandom_range(1, 20);
          for (k = 0; k < n; k++)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        10: begin
          if ($urandom_range(0, 1)) send_char(tcce_pkg::CODE_FF, 1'b1);
          else wait_results_done();
        end
        default: begin
          case ($urandom_range(0, 3))
            0: write_attribute(8'h00);
            1: write_attribute(8'hFF);
            default: write_attribute(8'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
    wait_results_done();
  endtask

  // Result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin : result_check
    tcce_pkg::result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_screen_ops.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: unexpected beat kind=%0d idx=%0d word=%h pos=%0d last=%b",
                   kind, cell_index, cell_word, cursor_pos, last);
      end else begin
        want = pending_screen_ops.pop_front();
        if (kind == tcce_pkg::KIND_CELL) cells_seen++;
        if (kind == tcce_pkg::KIND_CLEAR) clears_seen++;
        if (kind !== want.kind || cell_index !== want.cell_index ||
            cell_word !== want.cell_word || cursor_pos !== want.cursor_pos ||
            last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: beat mismatch at %0t", $realtime);
            $display("  expected kind=%0d idx=%0d word=%h pos=%0d last=%b",
                     want.kind, want.cell_index, want.cell_word, want.cursor_pos,
                     want.last);
            $display("  actual   kind=%0d idx=%0d word=%h pos=%0d last=%b",
                     kind, cell_index, cell_word, cursor_pos, last);
          end
        end
      end
    end
  end

  // Receiver: random hold before each beat, or a long hold on request
  initial begin : result_stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        n = $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Test sequence
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    ch             = '0;
    last_of_string = 1'b0;
    trk_row        = 0;
    trk_col        = 0;
    trk_attr       = tcce_pkg::ATTR_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_control_codes();
    test_attribute_extremes();
    test_backpressure();
    test_random_text();
    wait_results_done();

    $display("Run: %0d bytes in, %0d cells written, %0d screen clears, %0d attribute writes,",
             chars_sent, cells_seen, clears_seen, attr_writes);
    $display("with wraps, every control code, a long output hold and random gaps on both sides.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching beats", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
